FILE: hdl/lpm_pkg.sv
package lpm_pkg;

  // Default table geometry
  localparam int TABLE_ENTRIES_DEF = 16;
  localparam int PORT_BITS_DEF     = 4;

  // Field widths of the stream beats
  localparam int INDEX_W   = 4;
  localparam int PORT_W    = 4;
  localparam int WORD_W    = 32;

  // Input tdata layout, lowest bit first
  localparam int IN_IDX_LSB   = 0;
  localparam int IN_VALID_LSB = IN_IDX_LSB + INDEX_W;
  localparam int IN_DEST_LSB  = IN_VALID_LSB + 1;
  localparam int IN_MASK_LSB  = IN_DEST_LSB + WORD_W;
  localparam int IN_PORT_LSB  = IN_MASK_LSB + WORD_W;
  localparam int IN_ADDR_LSB  = IN_PORT_LSB + PORT_W;
  localparam int IN_USED_W    = IN_ADDR_LSB + WORD_W;
  localparam int IN_DATA_W    = ((IN_USED_W + 7) / 8) * 8;

  // Output tdata layout, lowest bit first
  localparam int OUT_HIT_LSB  = 0;
  localparam int OUT_IDX_LSB  = OUT_HIT_LSB + 1;
  localparam int OUT_PORT_LSB = OUT_IDX_LSB + INDEX_W;
  localparam int OUT_MASK_LSB = OUT_PORT_LSB + PORT_W;
  localparam int OUT_USED_W   = OUT_MASK_LSB + WORD_W;
  localparam int OUT_DATA_W   = ((OUT_USED_W + 7) / 8) * 8;

  // Command codes carried in the input tuser
  localparam logic CMD_WRITE  = 1'b0;
  localparam logic CMD_LOOKUP = 1'b1;

endpackage

FILE: hdl/lpm_table.sv
module lpm_table #(
  parameter int ENTRIES = 16,
  parameter int DATA_W  = 69
) (
  input  logic                       clk_i,
  input  logic                       we_i,
  input  logic [$clog2(ENTRIES)-1:0] waddr_i,
  input  logic [DATA_W-1:0]          wdata_i,
  input  logic [$clog2(ENTRIES)-1:0] raddr_i,
  output logic [DATA_W-1:0]          rdata_o
);

  logic [DATA_W-1:0] mem_q [ENTRIES];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_o <= mem_q[raddr_i];
  end

endmodule

FILE: hdl/longest_prefix_match_lookup_unit.sv
// IPv4 longest-prefix-match route table. A beat with tuser at the write code
// stores or clears one route (a slot at or above TABLE_ENTRIES is ignored but
// still acknowledged); a beat with tuser at the lookup code scans the table
// one route per cycle through a single compare unit and returns the valid
// match with the largest mask, lowest index on a tie. Every input beat gives
// exactly one output beat. A write goes from acceptance straight to S_DONE;
// a lookup passes through S_SCAN, where the single read port of the route
// memory is read once per entry, and then S_DONE. The input is not ready
// while an item is in flight. After reset the block clears the valid flags
// of every entry in the route memory before it takes its first input beat.
module longest_prefix_match_lookup_unit
  import lpm_pkg::*;
#(
  parameter int TABLE_ENTRIES = lpm_pkg::TABLE_ENTRIES_DEF,
  parameter int PORT_BITS     = lpm_pkg::PORT_BITS_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  // entry_index, entry_valid, entry_dest, entry_mask, entry_port, lookup_addr
  input  logic [lpm_pkg::IN_DATA_W-1:0]    s_axis_tdata,
  // command
  input  logic                             s_axis_tuser,
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  // hit, match_index, out_port, match_mask
  output logic [lpm_pkg::OUT_DATA_W-1:0]   m_axis_tdata,
  // write_done
  output logic                             m_axis_tuser
);

  localparam int IDX_W   = $clog2(TABLE_ENTRIES);
  localparam int CNT_W   = $clog2(TABLE_ENTRIES + 1);
  localparam int ENTRY_W = 2 * WORD_W + PORT_BITS + 1;

  typedef enum logic [3:0] {
    S_CLEAR = 4'b0001,
    S_IDLE  = 4'b0010,
    S_SCAN  = 4'b0100,
    S_DONE  = 4'b1000
  } state_e;

  state_e state_q, state_d;

  logic [CNT_W-1:0]      cnt_q, cnt_d;
  logic                  rd_vld_q, rd_vld_d;
  logic [IDX_W-1:0]      rd_idx_q, rd_idx_d;
  logic [WORD_W-1:0]     lk_addr_q, lk_addr_d;
  logic                  found_q, found_d;
  logic                  wr_q, wr_d;
  logic [IDX_W-1:0]      best_idx_q, best_idx_d;
  logic [WORD_W-1:0]     best_mask_q, best_mask_d;
  logic [PORT_BITS-1:0]  best_port_q, best_port_d;

  logic                  m_valid_q, m_valid_d;
  logic [OUT_DATA_W-1:0] m_data_q, m_data_d;
  logic                  m_user_q, m_user_d;

  // Input field view
  logic [INDEX_W-1:0] in_idx;
  logic               in_valid;
  logic [WORD_W-1:0]  in_dest;
  logic [WORD_W-1:0]  in_mask;
  logic [PORT_W-1:0]  in_port;
  logic [WORD_W-1:0]  in_addr;

  assign in_idx   = s_axis_tdata[IN_IDX_LSB +: INDEX_W];
  assign in_valid = s_axis_tdata[IN_VALID_LSB];
  assign in_dest  = s_axis_tdata[IN_DEST_LSB +: WORD_W];
  assign in_mask  = s_axis_tdata[IN_MASK_LSB +: WORD_W];
  assign in_port  = s_axis_tdata[IN_PORT_LSB +: PORT_W];
  assign in_addr  = s_axis_tdata[IN_ADDR_LSB +: WORD_W];

  logic [IDX_W+INDEX_W-1:0]    in_idx_ext;
  logic [PORT_BITS+PORT_W-1:0] in_port_ext;
  logic                        in_range;

  assign in_idx_ext  = {{IDX_W{1'b0}}, in_idx};
  assign in_port_ext = {{PORT_BITS{1'b0}}, in_port};
  assign in_range    = (32'(in_idx) < 32'(TABLE_ENTRIES));

  // Route memory
  logic               mem_we;
  logic [IDX_W-1:0]   mem_waddr;
  logic [ENTRY_W-1:0] mem_wdata;
  logic [IDX_W-1:0]   mem_raddr;
  logic [ENTRY_W-1:0] mem_rdata;

  lpm_table #(
    .ENTRIES(TABLE_ENTRIES),
    .DATA_W (ENTRY_W)
  ) u_table (
    .clk_i  (clk_i),
    .we_i   (mem_we),
    .waddr_i(mem_waddr),
    .wdata_i(mem_wdata),
    .raddr_i(mem_raddr),
    .rdata_o(mem_rdata)
  );

  logic [WORD_W-1:0]    r_dest;
  logic [WORD_W-1:0]    r_mask;
  logic [PORT_BITS-1:0] r_port;
  logic                 r_valid;

  assign r_dest  = mem_rdata[0 +: WORD_W];
  assign r_mask  = mem_rdata[WORD_W +: WORD_W];
  assign r_port  = mem_rdata[2*WORD_W +: PORT_BITS];
  assign r_valid = mem_rdata[ENTRY_W-1];

  // Shared compare unit: match test and mask ranking for one entry
  logic r_match;
  logic r_better;

  assign r_match  = r_valid && (((lk_addr_q ^ r_dest) & r_mask) == '0);
  assign r_better = !found_q || (r_mask > best_mask_q);

  assign mem_raddr = cnt_q[IDX_W-1:0];

  logic out_free;
  assign out_free      = !m_valid_q || m_axis_tready;
  assign s_axis_tready = (state_q == S_IDLE);

  logic [IDX_W+INDEX_W-1:0]    best_idx_ext;
  logic [PORT_BITS+PORT_W-1:0] best_port_ext;

  assign best_idx_ext  = {{INDEX_W{1'b0}}, best_idx_q};
  assign best_port_ext = {{PORT_W{1'b0}}, best_port_q};

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    rd_vld_d    = 1'b0;
    rd_idx_d    = rd_idx_q;
    lk_addr_d   = lk_addr_q;
    found_d     = found_q;
    wr_d        = wr_q;
    best_idx_d  = best_idx_q;
    best_mask_d = best_mask_q;
    best_port_d = best_port_q;
    m_valid_d   = m_valid_q && !m_axis_tready;
    m_data_d    = m_data_q;
    m_user_d    = m_user_q;
    mem_we      = 1'b0;
    mem_waddr   = cnt_q[IDX_W-1:0];
    mem_wdata   = '0;

    unique case (state_q)
      S_CLEAR: begin
        mem_we = 1'b1;
        if (cnt_q == CNT_W'(TABLE_ENTRIES - 1)) begin
          cnt_d   = '0;
          state_d = S_IDLE;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      S_IDLE: begin
        if (s_axis_tvalid) begin
          found_d = 1'b0;
          cnt_d   = '0;
          if (s_axis_tuser == CMD_WRITE) begin
            mem_we    = in_range;
            mem_waddr = in_idx_ext[IDX_W-1:0];
            mem_wdata = {in_valid, in_port_ext[PORT_BITS-1:0], in_mask, in_dest};
            wr_d      = 1'b1;
            state_d   = S_DONE;
          end else begin
            lk_addr_d = in_addr;
            wr_d      = 1'b0;
            state_d   = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        // issue one read per cycle; the compare runs in the cycle after each read
        if (cnt_q != CNT_W'(TABLE_ENTRIES)) begin
          rd_vld_d = 1'b1;
          rd_idx_d = cnt_q[IDX_W-1:0];
          cnt_d    = cnt_q + 1'b1;
        end else if (!rd_vld_q) begin
          state_d = S_DONE;
        end
        if (rd_vld_q && r_match && r_better) begin
          found_d     = 1'b1;
          best_idx_d  = rd_idx_q;
          best_mask_d = r_mask;
          best_port_d = r_port;
        end
      end
      S_DONE: begin
        if (out_free) begin
          m_valid_d = 1'b1;
          m_user_d  = wr_q;
          m_data_d  = '0;
          if (found_q) begin
            m_data_d[OUT_HIT_LSB]              = 1'b1;
            m_data_d[OUT_IDX_LSB +: INDEX_W]   = best_idx_ext[INDEX_W-1:0];
            m_data_d[OUT_PORT_LSB +: PORT_W]   = best_port_ext[PORT_W-1:0];
            m_data_d[OUT_MASK_LSB +: WORD_W]   = best_mask_q;
          end
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_CLEAR;
      cnt_q     <= '0;
      rd_vld_q  <= 1'b0;
      found_q   <= 1'b0;
      wr_q      <= 1'b0;
      m_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      cnt_q     <= cnt_d;
      rd_vld_q  <= rd_vld_d;
      found_q   <= found_d;
      wr_q      <= wr_d;
      m_valid_q <= m_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rd_idx_q    <= rd_idx_d;
    lk_addr_q   <= lk_addr_d;
    best_idx_q  <= best_idx_d;
    best_mask_q <= best_mask_d;
    best_port_q <= best_port_d;
    m_data_q    <= m_data_d;
    m_user_q    <= m_user_d;
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;
  assign m_axis_tuser  = m_user_q;

endmodule

FILE: hdl/lpm_checker.sv
module lpm_checker (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           s_axis_tvalid,
  input logic                           s_axis_tready,
  input logic                           m_axis_tvalid,
  input logic                           m_axis_tready,
  input logic [lpm_pkg::OUT_DATA_W-1:0] m_axis_tdata,
  input logic                           m_axis_tuser
);
  import lpm_pkg::*;

  // a stalled output beat holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
      && $stable(m_axis_tuser))
    else $error("output beat changed while stalled");

  // one item at a time: input drops right after a beat is taken
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("input ready while an item is in flight");

  // write acknowledge carries no lookup result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser |-> m_axis_tdata == '0)
    else $error("write acknowledge with nonzero result");

  // a miss reports zero index, port and mask
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tdata[OUT_HIT_LSB] |->
      m_axis_tdata[OUT_USED_W-1:OUT_IDX_LSB] == '0)
    else $error("miss with nonzero result fields");

endmodule

bind longest_prefix_match_lookup_unit lpm_checker u_lpm_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .s_axis_tvalid(s_axis_tvalid),
  .s_axis_tready(s_axis_tready),
  .m_axis_tvalid(m_axis_tvalid),
  .m_axis_tready(m_axis_tready),
  .m_axis_tdata (m_axis_tdata),
  .m_axis_tuser (m_axis_tuser)
);

FILE: sim/longest_prefix_match_lookup_unit_tb.sv
`timescale 1ns / 1ps

module longest_prefix_match_lookup_unit_tb;
  import lpm_pkg::*;

  localparam int TBL_ENTRIES = TABLE_ENTRIES_DEF;
  localparam int STALL_LIMIT = 2000;

  typedef struct {
    logic                hit;
    logic [INDEX_W-1:0]  index;
    logic [PORT_W-1:0]   port;
    logic [WORD_W-1:0]   mask;
    logic                write_done;
  } route_answer_t;

  logic                    clk_i = 1'b0;
  logic                    rst_ni = 1'b0;
  logic                    s_axis_tvalid = 1'b0;
  logic                    s_axis_tready;
  // entry_index, entry_valid, entry_dest, entry_mask, entry_port, lookup_addr
  logic [IN_DATA_W-1:0]    s_axis_tdata = '0;
  // command
  logic                    s_axis_tuser = CMD_WRITE;
  logic                    m_axis_tvalid;
  logic                    m_axis_tready = 1'b0;
  // hit, match_index, out_port, match_mask
  logic [OUT_DATA_W-1:0]   m_axis_tdata;
  // write_done
  logic                    m_axis_tuser;

  // Shadow copy of the route table
  logic                    rt_valid [TBL_ENTRIES];
  logic [WORD_W-1:0]       rt_dest  [TBL_ENTRIES];
  logic [WORD_W-1:0]       rt_mask  [TBL_ENTRIES];
  logic [PORT_BITS_DEF-1:0] rt_port [TBL_ENTRIES];

  route_answer_t           route_answers_q[$];
  int                      mismatch_count = 0;
  int                      send_idle_pct = 0;
  int                      recv_idle_pct = 0;
  int                      quiet_cycles = 0;

  longest_prefix_match_lookup_unit i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  always #5 clk_i = ~clk_i;

  initial begin
    for (int i = 0; i < TBL_ENTRIES; i++) rt_valid[i] = 1'b0;
  end

  // Apply one command to the shadow table and return the answer it should give
  function automatic route_answer_t resolve_route(
    input logic                 cmd,
    input logic [INDEX_W-1:0]   slot,
    input logic                 vld,
    input logic [WORD_W-1:0]    dest,
    input logic [WORD_W-1:0]    mask,
    input logic [PORT_W-1:0]    port,
    input logic [WORD_W-1:0]    addr
  );
    route_answer_t ans;
    logic          found;
    logic [WORD_W-1:0] best_mask;
    int            best;
    int            i;
    ans = '{hit: 1'b0, index: '0, port: '0, mask: '0, write_done: 1'b0};
    if (cmd == CMD_WRITE) begin
      if (int'(slot) < TBL_ENTRIES) begin
        rt_valid[slot] = vld;
        rt_dest[slot]  = dest;
        rt_mask[slot]  = mask;
        rt_port[slot]  = port[PORT_BITS_DEF-1:0];
      end
      ans.write_done = 1'b1;
    end else begin
      found = 1'b0;
      best_mask = '0;
      best = 0;
      for (i = 0; i < TBL_ENTRIES; i++) begin
        if (rt_valid[i] && ((addr & rt_mask[i]) == (rt_dest[i] & rt_mask[i])) &&
            (!found || rt_mask[i] > best_mask)) begin
          found = 1'b1;
          best_mask = rt_mask[i];
          best = i;
        end
      end
      if (found) begin
        ans.hit   = 1'b1;
        ans.index = best[INDEX_W-1:0];
        ans.port  = PORT_W'(rt_port[best]);
        ans.mask  = best_mask;
      end
    end
    return ans;
  endfunction

  task automatic send_beat(
    input logic                 cmd,
    input logic [INDEX_W-1:0]   slot,
    input logic                 vld,
    input logic [WORD_W-1:0]    dest,
    input logic [WORD_W-1:0]    mask,
    input logic [PORT_W-1:0]    port,
    input logic [WORD_W-1:0]    addr
  );
    logic [IN_DATA_W-1:0] beat;
    beat = '0;
    beat[IN_IDX_LSB +: INDEX_W]  = slot;
    beat[IN_VALID_LSB]           = vld;
    beat[IN_DEST_LSB +: WORD_W]  = dest;
    beat[IN_MASK_LSB +: WORD_W]  = mask;
    beat[IN_PORT_LSB +: PORT_W]  = port;
    beat[IN_ADDR_LSB +: WORD_W]  = addr;
    while ($urandom_range(99, 0) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= beat;
    s_axis_tuser  <= cmd;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    route_answers_q.push_back(resolve_route(cmd, slot, vld, dest, mask, port, addr));
  endtask

  task automatic write_route(
    input logic [INDEX_W-1:0] slot,
    input logic               vld,
    input logic [WORD_W-1:0]  dest,
    input logic [WORD_W-1:0]  mask,
    input logic [PORT_W-1:0]  port
  );
    send_beat(CMD_WRITE, slot, vld, dest, mask, port, $urandom);
  endtask

  task automatic lookup_route(input logic [WORD_W-1:0] addr);
    send_beat(CMD_LOOKUP, INDEX_W'($urandom_range(15, 0)), 1'($urandom_range(1, 0)),
              $urandom, $urandom, PORT_W'($urandom_range(15, 0)), addr);
  endtask

  // Hold the input idle until every outstanding answer has come back
  task automatic wait_for_drain();
    s_axis_tvalid <= 1'b0;
    while (route_answers_q.size() != 0) @(posedge clk_i);
  endtask

  // Write every slot as a cleared route, then look up into the empty table
  task automatic test_table_clear();
    int i;
    for (i = 0; i < TBL_ENTRIES; i++) begin
      write_route(INDEX_W'(i), 1'b0, $urandom, $urandom, PORT_W'($urandom_range(15, 0)));
    end
    lookup_route(32'h0000_0000);
    lookup_route(32'hFFFF_FFFF);
    wait_for_drain();
  endtask

  task automatic test_directed_routes();
    write_route(4'd15, 1'b1, 32'hFFFF_FFFF, 32'h0000_0000, 4'd15);  // default route
    lookup_route(32'h0000_0000);
    write_route(4'd0, 1'b1, 32'h0A00_0000, 32'hFF00_0000, 4'd0);
    write_route(4'd1, 1'b1, 32'h0A01_0000, 32'hFFFF_0000, 4'd2);
    write_route(4'd2, 1'b1, 32'h0A01_0000, 32'hFFFF_0000, 4'd3);    // tie with slot 1
    lookup_route(32'h0A01_0203);
    lookup_route(32'h0A02_0304);
    write_route(4'd3, 1'b1, 32'h0A01_0203, 32'hFFFF_FFFF, 4'd4);    // host route
    lookup_route(32'h0A01_0203);
    write_route(4'd3, 1'b0, 32'h0A01_0203, 32'hFFFF_FFFF, 4'd4);    // clear it again
    lookup_route(32'h0A01_0203);
    // non-contiguous mask, numerically above the /16
    write_route(4'd4, 1'b1, 32'h0A01_0003, 32'hFFFF_00FF, 4'd5);
    lookup_route(32'h0A01_0203);
    write_route(4'd5, 1'b1, 32'h0000_0000, 32'hFFFF_FFFF, 4'd6);
    lookup_route(32'h0000_0000);
    lookup_route(32'hFFFF_FFFF);
    write_route(4'd15, 1'b0, 32'h0000_0000, 32'h0000_0000, 4'd0);
    lookup_route(32'hFFFF_FFFF);
    wait_for_drain();
  endtask

  task automatic test_random_traffic(input int beats, input int tx_idle, input int rx_idle);
    int n;
    int j;
    int plen;
    logic [WORD_W-1:0] m;
    logic [WORD_W-1:0] d;
    logic [WORD_W-1:0] a;
    send_idle_pct = tx_idle;
    recv_idle_pct = rx_idle;
    for (n = 0; n < beats; n++) begin
      if (n % 80 == 40) wait_for_drain();
      j = $urandom_range(TBL_ENTRIES - 1, 0);
      if ($urandom_range(99, 0) < 30) begin
        plen = $urandom_range(32, 0);
        case ($urandom_range(9, 0))
          0: m = $urandom;
          1, 2: m = rt_mask[j];
          default: m = (plen == 0) ? '0 : (32'hFFFF_FFFF << (32 - plen));
        endcase
        // reuse a stored destination now and then so that routes nest
        if ($urandom_range(1, 0)) d = rt_dest[j] ^ ($urandom >> $urandom_range(31, 0));
        else d = $urandom;
        write_route(INDEX_W'($urandom_range(15, 0)), ($urandom_range(99, 0) < 85), d, m,
                    PORT_W'($urandom_range(15, 0)));
      end else begin
        if ($urandom_range(3, 0) != 0) a = (rt_dest[j] & rt_mask[j]) | ($urandom & ~rt_mask[j]);
        else a = $urandom;
        lookup_route(a);
      end
    end
    wait_for_drain();
  endtask

  always @(posedge clk_i) begin
    m_axis_tready <= ($urandom_range(99, 0) >= recv_idle_pct);
  end

  always @(posedge clk_i) begin : check_answers
    route_answer_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (route_answers_q.size() == 0) begin
        $error("unexpected result beat: tdata %h tuser %b", m_axis_tdata, m_axis_tuser);
        mismatch_count++;
      end else begin
        want = route_answers_q.pop_front();
        if (m_axis_tdata[OUT_HIT_LSB] !== want.hit) begin
          $error("hit: expected %0d, got %0d", want.hit, m_axis_tdata[OUT_HIT_LSB]);
          mismatch_count++;
        end
        if (m_axis_tdata[OUT_IDX_LSB +: INDEX_W] !== want.index) begin
          $error("match_index: expected %0d, got %0d", want.index,
                 m_axis_tdata[OUT_IDX_LSB +: INDEX_W]);
          mismatch_count++;
        end
        if (m_axis_tdata[OUT_PORT_LSB +: PORT_W] !== want.port) begin
          $error("out_port: expected %0d, got %0d", want.port,
                 m_axis_tdata[OUT_PORT_LSB +: PORT_W]);
          mismatch_count++;
        end
        if (m_axis_tdata[OUT_MASK_LSB +: WORD_W] !== want.mask) begin
          $error("match_mask: expected %h, got %h", want.mask,
                 m_axis_tdata[OUT_MASK_LSB +: WORD_W]);
          mismatch_count++;
        end
        if (m_axis_tuser !== want.write_done) begin
          $error("write_done: expected %0d, got %0d", want.write_done, m_axis_tuser);
          mismatch_count++;
        end
      end
    end
  end

  // Abort when neither side moves a beat for too long
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("*** FAILED ***");
        $finish;
      end
    end
  end

  initial begin
    send_idle_pct = 36;
    recv_idle_pct = 69;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    test_table_clear();
    test_directed_routes();
    test_random_traffic(235, 36, 69);
    test_random_traffic(235, 69, 36);
    test_random_traffic(235, 0, 0);
    repeat (TBL_ENTRIES + 8) @(posedge clk_i);
    if (mismatch_count == 0 && route_answers_q.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
